[hw/rtl/dcb_pkg.sv]
// Package for the DC blocker with soft limiter: widths, fixed-point constants,
// status codes, register indexes, state machine types and the queue entry type.
// No dependencies.
package dcb_pkg;

  // Fixed-point format of the level, the gain and the filter values.
  localparam int FRAC_BITS = 16;
  localparam int ONE_VAL   = 1 << FRAC_BITS;

  localparam int LEVEL_W  = 17;
  localparam int GAIN_W   = 17;
  localparam int POLE_W   = 24;
  localparam int X_W      = 18;
  localparam int Y_W      = 25;
  localparam int ACC_W    = 27;
  localparam int PX_W     = 2 * X_W;
  localparam int PP_W     = POLE_W + 1 + Y_W;
  localparam int SAMPLE_W = 16;
  localparam int QUO_W    = 15;
  localparam int NUM_W    = Y_W + QUO_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W    = $clog2(DIV_STEPS + 1);

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 24;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_AW-1:0] CFG_GAIN = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_POLE = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd65536;
  localparam logic [POLE_W-1:0] POLE_RESET = 24'd16711680;

  localparam logic signed [ACC_W-1:0] Y_MAX = 27'sd16777215;
  localparam logic signed [ACC_W-1:0] Y_MIN = -27'sd16777216;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_SAT     = 2'd2,
    ST_LATCHED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FE_IDLE = 2'd0,
    FE_MUL  = 2'd1,
    FE_SUM  = 2'd2
  } fe_state_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_LOAD = 2'd2
  } bk_state_t;

  typedef struct packed {
    status_t               status;
    logic signed [Y_W-1:0] y;
  } q_entry_t;

endpackage

[hw/rtl/dcb_in_if.sv]
// Input channel of the DC blocker: valid/ready handshake with the level sample
// and the start-of-trace flag. Depends on dcb_pkg.
interface dcb_in_if import dcb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] terrain_level;
  logic               first;

  modport source (output valid, output terrain_level, output first, input ready);
  modport sink   (input valid, input terrain_level, input first, output ready);
endinterface

[hw/rtl/dcb_out_if.sv]
// Result channel of the DC blocker: valid/ready handshake with the limited
// sample and its status code. Depends on dcb_pkg.
interface dcb_out_if import dcb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [1:0]                 status;

  modport source (output valid, output sample, output status, input ready);
  modport sink   (input valid, input sample, input status, output ready);
endinterface

[hw/rtl/dcb_front.sv]
// Front end: configuration registers, input classification, gain and pole
// products, filter recursion with saturation check. Depends on dcb_pkg, dcb_in_if.
module dcb_front import dcb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dcb_in_if.sink            in_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output logic              push,
  output q_entry_t          push_entry,
  input  logic              q_full
);

  localparam logic signed [X_W:0]    ONE_B  = (X_W + 1)'(ONE_VAL);
  localparam logic signed [PX_W-1:0] X_HALF = PX_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PP_W-1:0] P_HALF = PP_W'(1) <<< (POLE_W - 1);

  fe_state_t state_r, state_nxt;

  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic [POLE_W-1:0] pole_r, pole_nxt;

  logic signed [X_W-1:0] prev_x_r, prev_x_nxt;
  logic signed [Y_W-1:0] prev_y_r, prev_y_nxt;
  logic                  fault_r, fault_nxt;

  logic signed [X_W-1:0]  b_r, b_nxt;
  status_t                cls_r, cls_nxt;
  logic signed [PX_W-1:0] prod_x_r;
  logic signed [PP_W-1:0] prod_p_r;

  logic                   accept;
  logic                   fault_eff;
  logic signed [X_W:0]    b_wide;
  logic signed [PX_W-1:0] x_round;
  logic signed [PP_W-1:0] p_round;
  logic signed [X_W-1:0]  x_val;
  logic signed [ACC_W-1:0] y_full;
  logic                   sat;

  assign accept    = in_ch.valid && in_ch.ready;
  assign fault_eff = fault_r && !in_ch.first;
  assign b_wide    = $signed({1'b0, in_ch.terrain_level, 1'b0}) - ONE_B;

  // Round half up: add half an LSB, then shift arithmetically.
  assign x_round = (prod_x_r + X_HALF) >>> FRAC_BITS;
  assign p_round = (prod_p_r + P_HALF) >>> POLE_W;
  assign x_val   = x_round[X_W-1:0];
  assign y_full  = ACC_W'(x_val) - ACC_W'(prev_x_r) + p_round[ACC_W-1:0];
  assign sat     = (y_full > Y_MAX) || (y_full < Y_MIN);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE: if (accept) state_nxt = FE_MUL;
      FE_MUL:  state_nxt = FE_SUM;
      FE_SUM:  if (!q_full) state_nxt = FE_IDLE;
      default: state_nxt = FE_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ch.ready = 1'b0;
    push        = 1'b0;
    unique case (state_r)
      FE_IDLE: in_ch.ready = 1'b1;
      FE_MUL:  ;
      FE_SUM:  push = !q_full;
      default: ;
    endcase
  end

  always_comb begin
    push_entry.status = cls_r;
    push_entry.y      = y_full[Y_W-1:0];
    if (cls_r == ST_OK && sat) begin
      push_entry.status = ST_SAT;
    end
  end

  // Configuration, item capture and filter state.
  always_comb begin
    gain_nxt   = gain_r;
    pole_nxt   = pole_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    fault_nxt  = fault_r;
    b_nxt      = b_r;
    cls_nxt    = cls_r;

    if (cfg_we) begin
      if (cfg_addr == CFG_GAIN) gain_nxt = cfg_wdata[GAIN_W-1:0];
      if (cfg_addr == CFG_POLE) pole_nxt = cfg_wdata[POLE_W-1:0];
    end

    if (accept) begin
      b_nxt = b_wide[X_W-1:0];
      if (in_ch.first) begin
        prev_x_nxt = '0;
        prev_y_nxt = '0;
        fault_nxt  = 1'b0;
      end
      priority if (fault_eff) begin
        cls_nxt = ST_LATCHED;
      end else if (in_ch.terrain_level > LEVEL_W'(ONE_VAL)) begin
        cls_nxt   = ST_RANGE;
        fault_nxt = 1'b1;
      end else begin
        cls_nxt = ST_OK;
      end
    end

    if (push && cls_r == ST_OK) begin
      if (sat) begin
        fault_nxt = 1'b1;
      end else begin
        prev_x_nxt = x_val;
        prev_y_nxt = y_full[Y_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FE_IDLE;
      gain_r   <= GAIN_RESET;
      pole_r   <= POLE_RESET;
      prev_x_r <= '0;
      prev_y_r <= '0;
      fault_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      gain_r   <= gain_nxt;
      pole_r   <= pole_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
      fault_r  <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r   <= b_nxt;
    cls_r <= cls_nxt;
    if (state_r == FE_MUL) begin
      prod_x_r <= $signed({1'b0, gain_r}) * b_r;
      prod_p_r <= $signed({1'b0, pole_r}) * prev_y_r;
    end
  end

  a_latched_class: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fault_r && !in_ch.first) |=> (cls_r == ST_LATCHED))
    else $error("latched fault did not classify the next transaction");

  a_fault_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.status != ST_OK) |=> fault_r)
    else $error("faulted transaction left no latched fault");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready ##1 !in_ch.ready)
    else $error("front accepted a transaction while one was in flight");

endmodule

[hw/rtl/dcb_fifo.sv]
// Short queue between the front end and the divider back end; holds the
// status and filter output of classified items. Depends on dcb_pkg.
module dcb_fifo import dcb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_entry,
  output logic     empty
);

  q_entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign empty     = (cnt_r == '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond its depth");

endmodule

[hw/rtl/dcb_back.sv]
// Back end: soft limiter y/(1+|y|) through a restoring divider, one quotient
// bit per cycle, and the output register. Depends on dcb_pkg, dcb_out_if.
module dcb_back import dcb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  output logic     pop,
  input  q_entry_t pop_entry,
  input  logic     empty,
  dcb_out_if.source out_ch
);

  bk_state_t state_r, state_nxt;

  logic [Y_W-1:0]   rem_r, rem_nxt;
  logic [Y_W-1:0]   den_r, den_nxt;
  logic [QUO_W-1:0] nlo_r, nlo_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  status_t                    out_status_r, out_status_nxt;

  logic             slot_free;
  logic             load_fault;
  logic             load_ok;
  logic             entry_ok;
  logic [Y_W-1:0]   mag;
  logic [Y_W-1:0]   den;
  logic [NUM_W-1:0] num;
  logic [Y_W:0]     trial;
  logic             ge;
  logic [SAMPLE_W-1:0] quo_ext;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign entry_ok  = (pop_entry.status == ST_OK);

  // Operands of the limiter: q = (|y|*2^15 + den/2) / den with den = 1 + |y|.
  assign mag = pop_entry.y[Y_W-1] ? Y_W'(-pop_entry.y) : Y_W'(pop_entry.y);
  assign den = Y_W'(ONE_VAL) + mag;
  assign num = {mag, QUO_W'(0)} + NUM_W'(den >> 1);

  assign trial   = {rem_r, nlo_r[QUO_W-1]};
  assign ge      = (trial >= {1'b0, den_r});
  assign quo_ext = {1'b0, quo_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!empty && entry_ok) state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = BK_LOAD;
      BK_LOAD: if (slot_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    pop        = 1'b0;
    load_fault = 1'b0;
    load_ok    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        pop        = !empty && (entry_ok || slot_free);
        load_fault = !empty && !entry_ok && slot_free;
      end
      BK_DIV:  ;
      BK_LOAD: load_ok = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    rem_nxt = rem_r;
    den_nxt = den_r;
    nlo_nxt = nlo_r;
    quo_nxt = quo_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    if (pop && entry_ok) begin
      rem_nxt = num[NUM_W-1:QUO_W];
      nlo_nxt = num[QUO_W-1:0];
      den_nxt = den;
      neg_nxt = pop_entry.y[Y_W-1];
      quo_nxt = '0;
      cnt_nxt = '0;
    end else if (state_r == BK_DIV) begin
      rem_nxt = ge ? Y_W'(trial - {1'b0, den_r}) : trial[Y_W-1:0];
      nlo_nxt = {nlo_r[QUO_W-2:0], 1'b0};
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_sample_nxt = out_sample_r;
    out_status_nxt = out_status_r;
    if (load_fault) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = '0;
      out_status_nxt = pop_entry.status;
    end else if (load_ok) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = neg_r ? $signed(-quo_ext) : $signed(quo_ext);
      out_status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    den_r        <= den_nxt;
    nlo_r        <= nlo_nxt;
    quo_r        <= quo_nxt;
    neg_r        <= neg_nxt;
    out_sample_r <= out_sample_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;
  assign out_ch.status = out_status_r;

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divider ran past its last step");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_sample_r == '0))
    else $error("faulted result carries a nonzero sample");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_LOAD && slot_free) |=> (out_valid_r && out_status_r == ST_OK))
    else $error("finished quotient did not reach the output register");

endmodule

[hw/rtl/dc_block_soft_limit_voice.sv]
// Top level of the DC blocker with soft limiter: front end, queue and divider
// back end. Depends on dcb_pkg, dcb_in_if, dcb_out_if and the dcb_* modules.
//
//   Port group | Direction | Handshake          | Payload
//   in_ch      | sink      | valid / ready      | terrain_level[16:0], first
//   out_ch     | source    | valid / ready      | sample[15:0] signed, status[1:0]
//   cfg_*      | sink      | cfg_we, no ready   | cfg_addr[0], cfg_wdata[23:0]
//
// The front end takes a new transaction only after it has pushed the previous
// one, which waits while the queue is full. The back end takes an ok result
// through pop, 15 divider steps of one quotient bit each, and load before it
// pops the next; a faulted result is popped and loaded when the output is free.
// Reset is synchronous and active low; it restores register defaults and
// clears the filter state. A stalled output stops the back end, and the queue
// lets the front end keep accepting until it fills.
module dc_block_soft_limit_voice import dcb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dcb_in_if.sink            in_ch,
  dcb_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     pop;
  q_entry_t pop_entry;
  logic     q_empty;

  dcb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  dcb_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  dcb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_entry (pop_entry),
    .empty     (q_empty),
    .out_ch    (out_ch)
  );

endmodule
